// ----- rtl/assert_macros.svh -----
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under reset
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/yrbd_pkg.sv -----
`timescale 1ns / 1ps
package yrbd_pkg;

    localparam int NUM_W = 48;
    localparam int DEN_W = 41;
    localparam int DIV_CNT_W = 6;

    localparam logic [2:0] FLD_TX  = 3'd0;
    localparam logic [2:0] FLD_TY  = 3'd1;
    localparam logic [2:0] FLD_TW  = 3'd2;
    localparam logic [2:0] FLD_TH  = 3'd3;
    localparam logic [2:0] FLD_OBJ = 3'd4;
    localparam logic [2:0] FLD_CLS = 3'd5;

    localparam logic [1:0] REG_ANCHOR_W = 2'd0;
    localparam logic [1:0] REG_ANCHOR_H = 2'd1;
    localparam logic [1:0] REG_IN_W     = 2'd2;
    localparam logic [1:0] REG_IN_H     = 2'd3;

    localparam logic [39:0] ANCHOR_W_RESET = 40'h445E24210D;
    localparam logic [39:0] ANCHOR_H_RESET = 40'h763F572A18;
    localparam logic [9:0]  IN_DIM_RESET   = 10'd160;

    localparam logic signed [17:0] LOG2E_Q14 = 18'sd23637;
    localparam logic signed [35:0] EXP_BIAS  = 36'sd805306368;  // 12 << 26
    localparam logic [16:0] POLY_C0 = 17'd5121;
    localparam logic [16:0] POLY_C1 = 17'd14822;
    localparam logic [16:0] POLY_C2 = 17'd45584;
    localparam logic [16:0] POLY_C3 = 17'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_Y,
        ST_MUL_P1,
        ST_MUL_P2,
        ST_MUL_P3,
        ST_MUL_A,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_NEXT_FIELD,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [15:0] sat16(input logic [NUM_W-1:0] v);
        logic [15:0] r;
        r = (v > NUM_W'(16'hFFFF)) ? 16'hFFFF : v[15:0];
        return r;
    endfunction

endpackage

// ----- rtl/yrbd_divider.sv -----
`timescale 1ns / 1ps
module yrbd_divider
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [yrbd_pkg::NUM_W-1:0] num,
    input  logic [yrbd_pkg::DEN_W-1:0] den,
    output yrbd_pkg::div_stat_t       stat,
    output logic [yrbd_pkg::NUM_W-1:0] quotient
);
    import yrbd_pkg::*;

    logic [NUM_W-1:0]     num_reg, num_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DEN_W:0]       trial;
    logic                 fits;

    // restoring division, one quotient bit a cycle, quotient shifts into num
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            cnt_next  = DIV_CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            num_next = {num_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = num_reg;

endmodule

// ----- rtl/yolo_region_box_decode_top.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// in        into block in_valid / in_stall   raw_tx .. raw_class
// out       from block out_valid / out_stall box_center_x .. last_of_frame
// cfg       into block psel/penable/pwrite   paddr, pwdata, prdata
//
// six fields pass one after another through one shared 18x18 multiplier (exp polynomial)
// and one 48-step restoring divider; the next request is not taken while the output stays stalled
// in_stall stays high from acceptance until the result is loaded into the output register
// a stalled output holds the block in its final state; reset clears counters and restores config defaults

`include "assert_macros.svh"

module yolo_region_box_decode_top
#(
    parameter int GRID_SIZE   = 5,
    parameter int NUM_ANCHORS = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] raw_tx,
    input  logic [15:0] raw_ty,
    input  logic [15:0] raw_tw,
    input  logic [15:0] raw_th,
    input  logic [15:0] raw_objectness,
    input  logic [15:0] raw_class,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] box_center_x,
    output logic [15:0] box_center_y,
    output logic [15:0] box_width,
    output logic [15:0] box_height,
    output logic [15:0] objectness,
    output logic [15:0] class_score,
    output logic [2:0]  anchor_index,
    output logic [2:0]  cell_column,
    output logic [2:0]  cell_row,
    output logic        last_of_frame,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import yrbd_pkg::*;

    localparam int CW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam int AW = (NUM_ANCHORS > 1) ? $clog2(NUM_ANCHORS) : 1;

    // division by the grid size as a reciprocal multiply, exact for numerators below 2^22
    localparam int CTR_N = 22;
    localparam int CTR_S = CTR_N + $clog2(GRID_SIZE);
    localparam logic [23:0] CTR_M =
        24'(((64'd1 << CTR_S) + 64'(GRID_SIZE) - 64'd1) / 64'(GRID_SIZE));

    // configuration
    logic [39:0] anc_w_reg, anc_h_reg;
    logic [9:0]  in_w_reg, in_h_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:3];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anc_w_reg <= ANCHOR_W_RESET;
            anc_h_reg <= ANCHOR_H_RESET;
            in_w_reg  <= IN_DIM_RESET;
            in_h_reg  <= IN_DIM_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ANCHOR_W: anc_w_reg <= pwdata[39:0];
                REG_ANCHOR_H: anc_h_reg <= pwdata[39:0];
                REG_IN_W:     in_w_reg  <= pwdata[9:0];
                REG_IN_H:     in_h_reg  <= pwdata[9:0];
                default:      anc_w_reg <= anc_w_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ANCHOR_W: prdata = 64'(anc_w_reg);
            REG_ANCHOR_H: prdata = 64'(anc_h_reg);
            REG_IN_W:     prdata = 64'(in_w_reg);
            REG_IN_H:     prdata = 64'(in_h_reg);
            default:      prdata = '0;
        endcase
    end

    // sequencer state and datapath registers
    seq_state_t       state_reg, state_next;
    logic [2:0]       fld_reg;
    logic [15:0]      raw_reg [6];
    logic [4:0]       n_reg;
    logic [15:0]      f_reg;
    logic [16:0]      p_reg;
    logic [16:0]      sig_reg;
    logic [24:0]      prod_reg;
    logic [15:0]      res_reg [6];
    logic [AW-1:0]    anc_reg;
    logic [CW-1:0]    col_reg, row_reg;
    logic             out_valid_reg;
    logic [15:0]      out_res_reg [6];
    logic [2:0]       out_anc_reg, out_col_reg, out_row_reg;
    logic             out_last_reg;

    logic             is_center, is_size, is_last_fld;
    logic signed [16:0] r17;
    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] prod;
    logic signed [35:0] y_val;
    logic [17:0]      poly_sum;
    logic [16:0]      poly_c;
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    div_stat_t        div_stat;
    logic [NUM_W-1:0] div_q;
    logic [63:0]      anc_w_wide, anc_h_wide;
    logic [2:0]       anc3;
    logic [7:0]       anchor_px;
    logic [9:0]       divisor;
    logic [CW-1:0]    cnt_sel;
    logic             out_free;
    logic             frame_last;
    logic [7:0]       anc_wide, col_wide, row_wide;
    logic [21:0]      ctr_num;
    logic [45:0]      ctr_prod;
    logic [NUM_W-1:0] ctr_q;

    assign is_center   = (fld_reg == FLD_TX) || (fld_reg == FLD_TY);
    assign is_size     = (fld_reg == FLD_TW) || (fld_reg == FLD_TH);
    assign is_last_fld = (fld_reg == FLD_CLS);
    assign out_free    = !(out_valid_reg && out_stall);

    // sigmoid fields evaluate exp of the negated logit
    assign r17 = is_size ? 17'(signed'(raw_reg[fld_reg]))
                         : -17'(signed'(raw_reg[fld_reg]));

    assign anc_wide   = 8'(anc_reg);
    assign col_wide   = 8'(col_reg);
    assign row_wide   = 8'(row_reg);
    assign anc3       = anc_wide[2:0];
    assign anc_w_wide = 64'(anc_w_reg);
    assign anc_h_wide = 64'(anc_h_reg);
    assign anchor_px  = (fld_reg == FLD_TW) ? anc_w_wide[8*anc3 +: 8] : anc_h_wide[8*anc3 +: 8];
    assign divisor    = (fld_reg == FLD_TW) ? ((in_w_reg == '0) ? 10'd1 : in_w_reg)
                                            : ((in_h_reg == '0) ? 10'd1 : in_h_reg);
    assign cnt_sel    = (fld_reg == FLD_TX) ? col_reg : row_reg;
    assign frame_last = (anc_reg == AW'(NUM_ANCHORS - 1)) && (col_reg == CW'(GRID_SIZE - 1))
                     && (row_reg == CW'(GRID_SIZE - 1));

    // center: (sigmoid + count * 65536) / GRID_SIZE
    assign ctr_num  = 22'(sig_reg) + (22'(cnt_sel) << 16);
    assign ctr_prod = 46'(ctr_num) * 46'(CTR_M);
    assign ctr_q    = NUM_W'(ctr_prod >> CTR_S);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:       if (in_valid) state_next = ST_MUL_Y;
            ST_MUL_Y:      state_next = ST_MUL_P1;
            ST_MUL_P1:     state_next = ST_MUL_P2;
            ST_MUL_P2:     state_next = ST_MUL_P3;
            ST_MUL_P3:     state_next = is_size ? ST_MUL_A : ST_DIV_START;
            ST_MUL_A:      state_next = ST_DIV_START;
            ST_DIV_START:  state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                    state_next = ST_NEXT_FIELD;
            end
            ST_NEXT_FIELD: state_next = is_last_fld ? ST_OUT : ST_MUL_Y;
            ST_OUT:        if (out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // control outputs and shared unit operands
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        div_start = (state_reg == ST_DIV_START);
        mul_a     = {1'b0, p_reg};
        mul_b     = {2'b00, f_reg};
        poly_c    = POLY_C1;
        case (state_reg)
            ST_MUL_Y:
            begin
                mul_a = 18'(r17);
                mul_b = LOG2E_Q14;
            end
            ST_MUL_P1: poly_c = POLY_C1;
            ST_MUL_P2: poly_c = POLY_C2;
            ST_MUL_P3: poly_c = POLY_C3;
            ST_MUL_A:  mul_b = {10'd0, anchor_px};
            default:   poly_c = POLY_C1;
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign y_val    = prod + EXP_BIAS;
    assign poly_sum = 18'(poly_c) + 18'(prod[32:16]);

    always_comb
    begin
        if (is_size)
        begin
            div_num = (NUM_W'(prod_reg) << n_reg) >> 16;
            div_den = DEN_W'(divisor);
        end
        else
        begin
            div_num = NUM_W'(1) << 44;
            div_den = (DEN_W'(1) << 28) + (DEN_W'(p_reg) << n_reg);
        end
    end

    yrbd_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .stat     (div_stat),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fld_reg       <= FLD_TX;
            anc_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    fld_reg <= FLD_TX;
                ST_NEXT_FIELD:
                    fld_reg <= fld_reg + 3'd1;
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        // anchor innermost, then column, then row
                        if (anc_reg == AW'(NUM_ANCHORS - 1))
                        begin
                            anc_reg <= '0;
                            if (col_reg == CW'(GRID_SIZE - 1))
                            begin
                                col_reg <= '0;
                                row_reg <= (row_reg == CW'(GRID_SIZE - 1)) ? '0 : row_reg + 1'b1;
                            end
                            else
                                col_reg <= col_reg + 1'b1;
                        end
                        else
                            anc_reg <= anc_reg + 1'b1;
                    end
                end
                default: fld_reg <= fld_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    raw_reg[0] <= raw_tx;
                    raw_reg[1] <= raw_ty;
                    raw_reg[2] <= raw_tw;
                    raw_reg[3] <= raw_th;
                    raw_reg[4] <= raw_objectness;
                    raw_reg[5] <= raw_class;
                end
            end
            ST_MUL_Y:
            begin
                n_reg <= y_val[30:26];
                f_reg <= y_val[25:10];
                p_reg <= POLY_C0;
            end
            ST_MUL_P1, ST_MUL_P2, ST_MUL_P3: p_reg <= poly_sum[16:0];
            ST_MUL_A:  prod_reg <= prod[24:0];
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (is_center)
                        sig_reg <= div_q[16:0];
                    else
                        res_reg[fld_reg] <= sat16(div_q);
                end
            end
            ST_NEXT_FIELD:
            begin
                if (is_center)
                    res_reg[fld_reg] <= sat16(ctr_q);
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    for (int i = 0; i < 6; i++)
                        out_res_reg[i] <= res_reg[i];
                    out_anc_reg  <= anc3;
                    out_col_reg  <= col_wide[2:0];
                    out_row_reg  <= row_wide[2:0];
                    out_last_reg <= frame_last;
                end
            end
            default: n_reg <= n_reg;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign box_center_x  = out_res_reg[0];
    assign box_center_y  = out_res_reg[1];
    assign box_width     = out_res_reg[2];
    assign box_height    = out_res_reg[3];
    assign objectness    = out_res_reg[4];
    assign class_score   = out_res_reg[5];
    assign anchor_index  = out_anc_reg;
    assign cell_column   = out_col_reg;
    assign cell_row      = out_row_reg;
    assign last_of_frame = out_last_reg;

    `ASSERT_IMPLIES(a_div_done_in_wait, clk, rst_n, div_stat.done, state_reg == ST_DIV_WAIT)
    `ASSERT_NEXT(a_accept_starts_seq, clk, rst_n, in_valid && !in_stall, state_reg == ST_MUL_Y)
    `ASSERT_IMPLIES(a_counters_in_range, clk, rst_n, 1'b1, (anc_reg < AW'(NUM_ANCHORS)) && (col_reg < CW'(GRID_SIZE)) && (row_reg < CW'(GRID_SIZE)))

endmodule
